[rtl/mtts_pkg.sv]
package mtts_pkg;

  localparam int TAPES = 2;
  localparam int SYM_W = 8;
  localparam int ST_W = 4;
  localparam int DEF_TAPE_DEPTH = 1024;
  localparam int DEF_RULE_DEPTH = 64;

  localparam logic [SYM_W-1:0] SYM_ANY = 8'd42;
  localparam logic [SYM_W-1:0] SYM_BLANK = 8'd95;
  localparam logic [1:0] MOVE_LEFT = 2'd1;
  localparam logic [1:0] MOVE_RIGHT = 2'd2;

  localparam logic [2:0] REQ_LOAD = 3'd0;
  localparam logic [2:0] REQ_BEGIN = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_RUN = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_ACCEPT = 2'd1;
  localparam logic [1:0] STAT_REJECT = 2'd2;
  localparam logic [1:0] STAT_LIMIT = 2'd3;

  localparam logic [2:0] CFG_START = 3'd0;
  localparam logic [2:0] CFG_ACCEPT = 3'd1;
  localparam logic [2:0] CFG_REJECT = 3'd2;
  localparam logic [2:0] CFG_TAPE_LEN = 3'd3;
  localparam logic [2:0] CFG_STEP_LIMIT = 3'd4;
  localparam logic [2:0] CFG_RULE_COUNT = 3'd5;

  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 48;

  typedef struct packed {
    logic [ST_W-1:0] from_st;
    logic [ST_W-1:0] to_st;
    logic [TAPES*SYM_W-1:0] rd;
    logic [TAPES*SYM_W-1:0] wr;
    logic [2*TAPES-1:0] mv;
  } rule_t;

  typedef struct packed {
    logic latch;
    logic rule_wr;
    logic begin_init;
    logic clr_step;
    logic cell_wr;
    logic cell_rd;
    logic head_rd;
    logic ridx_clr;
    logic rule_rd;
    logic ridx_inc;
    logic set_reject;
    logic apply;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic clr_last;
    logic halt;
    logic ridx_end;
    logic match;
    logic out_free;
  } sts_t;

endpackage

[rtl/mtts_ctrl.sv]
module mtts_ctrl import mtts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_CLEAR, S_CHK, S_FETCH, S_MATCH, S_APPLY, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic clr_item_r, clr_item_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_item_nxt = clr_item_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.req)
          REQ_LOAD: begin
            cmd.rule_wr = 1'b1;
            state_nxt = S_RESP;
          end
          REQ_BEGIN: begin
            cmd.begin_init = 1'b1;
            clr_item_nxt = 1'b1;
            state_nxt = S_CLEAR;
          end
          REQ_WRITE: begin
            cmd.cell_wr = 1'b1;
            state_nxt = S_RESP;
          end
          REQ_RUN: state_nxt = S_CHK;
          REQ_READ: begin
            cmd.cell_rd = 1'b1;
            state_nxt = S_RESP;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = clr_item_r ? S_RESP : S_IDLE;
          clr_item_nxt = 1'b0;
        end
      end
      S_CHK: begin
        if (sts.halt) begin
          state_nxt = S_RESP;
        end else begin
          cmd.head_rd = 1'b1;
          cmd.ridx_clr = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts.ridx_end) begin
          cmd.set_reject = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.rule_rd = 1'b1;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        if (sts.match) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.ridx_inc = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_CHK;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_item_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rule_wr, cmd.clr_step, cmd.cell_wr, cmd.apply}))
    else $error("tape/rule write sources collide");

  a_apply_after_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> $past(sts.match))
    else $error("apply without a matching rule");

  a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> !in_tready)
    else $error("ready while an item is in work");

endmodule

[rtl/mtts_dp.sv]
module mtts_dp import mtts_pkg::*; #(
  parameter int TAPE_DEPTH = DEF_TAPE_DEPTH,
  parameter int RULE_DEPTH = DEF_RULE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [2:0]            in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int RW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int RCW = $clog2(RULE_DEPTH + 1);

  logic [ST_W-1:0] start_r, acc_r, rej_r;
  logic [10:0] tape_len_r;
  logic [31:0] step_lim_r;
  logic [6:0] rule_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 4'd0;
      acc_r <= 4'd1;
      rej_r <= 4'd2;
      tape_len_r <= 11'd1024;
      step_lim_r <= 32'd10000;
      rule_cnt_r <= 7'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_START:      start_r <= cfg_data[ST_W-1:0];
        CFG_ACCEPT:     acc_r <= cfg_data[ST_W-1:0];
        CFG_REJECT:     rej_r <= cfg_data[ST_W-1:0];
        CFG_TAPE_LEN:   tape_len_r <= cfg_data[10:0];
        CFG_STEP_LIMIT: step_lim_r <= cfg_data;
        CFG_RULE_COUNT: rule_cnt_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [2:0] req_r;
  logic [IN_DATA_W-1:0] item_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_tuser;
      item_r <= in_tdata;
    end
  end

  logic [5:0] rule_index;
  rule_t new_rule;
  logic tape_sel;
  logic [9:0] cell_pos;
  logic [SYM_W-1:0] cell_sym;
  logic addr_ok;
  logic [AW-1:0] pos_a;

  assign rule_index = item_r[5:0];
  assign new_rule.from_st = item_r[9:6];
  assign new_rule.rd = item_r[25:10];
  assign new_rule.to_st = item_r[29:26];
  assign new_rule.wr = item_r[45:30];
  assign new_rule.mv = item_r[49:46];
  assign tape_sel = item_r[50];
  assign cell_pos = item_r[60:51];
  assign cell_sym = item_r[68:61];
  assign addr_ok = (32'(tape_sel) < TAPES) && (32'(cell_pos) < TAPE_DEPTH);
  assign pos_a = AW'(cell_pos);

  logic [31:0] lim, rule_n;

  always_comb begin
    if (tape_len_r == 11'd0) lim = 32'd1;
    else if (32'(tape_len_r) > TAPE_DEPTH) lim = TAPE_DEPTH;
    else lim = 32'(tape_len_r);
    if (32'(rule_cnt_r) > RULE_DEPTH) rule_n = RULE_DEPTH;
    else rule_n = 32'(rule_cnt_r);
  end

  rule_t rule_mem [RULE_DEPTH];
  rule_t rule_q;
  logic [RCW-1:0] ridx_r;

  always_ff @(posedge clk) begin
    if (cmd.rule_wr && (32'(rule_index) < RULE_DEPTH))
      rule_mem[RW'(rule_index)] <= new_rule;
    if (cmd.rule_rd) rule_q <= rule_mem[ridx_r[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ridx_r <= '0;
    else if (cmd.ridx_clr) ridx_r <= '0;
    else if (cmd.ridx_inc) ridx_r <= ridx_r + RCW'(1);
  end

  logic [AW-1:0] clr_cnt_r;
  logic clr_last;
  assign clr_last = (clr_cnt_r == AW'(TAPE_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clr_step) clr_cnt_r <= clr_last ? '0 : clr_cnt_r + AW'(1);
  end

  logic [AW-1:0] head_r [TAPES];
  logic [AW-1:0] head_nxt [TAPES];
  logic [ST_W-1:0] mst_r, mst_nxt;
  logic [31:0] step_cnt_r, step_cnt_nxt;
  logic [SYM_W-1:0] sym_q [TAPES];

  for (genvar t = 0; t < TAPES; t++) begin : g_tape
    logic [SYM_W-1:0] mem [TAPE_DEPTH];
    logic [SYM_W-1:0] wr_sym;
    logic we;
    logic [AW-1:0] wa;
    logic [SYM_W-1:0] wd;

    assign wr_sym = rule_q.wr[SYM_W*t +: SYM_W];

    always_comb begin
      we = 1'b0;
      wa = head_r[t];
      wd = wr_sym;
      if (cmd.clr_step) begin
        we = 1'b1;
        wa = clr_cnt_r;
        wd = SYM_BLANK;
      end else if (cmd.cell_wr) begin
        we = addr_ok && (32'(tape_sel) == t);
        wa = pos_a;
        wd = cell_sym;
      end else if (cmd.apply) begin
        we = (wr_sym != SYM_ANY);
      end
    end

    always_ff @(posedge clk) begin
      if (we) mem[wa] <= wd;
      if (cmd.cell_rd) sym_q[t] <= mem[pos_a];
      else if (cmd.head_rd) sym_q[t] <= mem[head_r[t]];
    end
  end

  logic match;

  always_comb begin
    match = (rule_q.from_st == mst_r);
    for (int t = 0; t < TAPES; t++) begin
      if (rule_q.rd[SYM_W*t +: SYM_W] != SYM_ANY &&
          rule_q.rd[SYM_W*t +: SYM_W] != sym_q[t]) match = 1'b0;
    end
  end

  always_comb begin
    mst_nxt = mst_r;
    step_cnt_nxt = step_cnt_r;
    for (int t = 0; t < TAPES; t++) begin
      head_nxt[t] = head_r[t];
      if (cmd.begin_init) begin
        head_nxt[t] = '0;
      end else if (cmd.apply) begin
        if (rule_q.mv[2*t +: 2] == MOVE_LEFT && head_r[t] != '0)
          head_nxt[t] = head_r[t] - AW'(1);
        else if (rule_q.mv[2*t +: 2] == MOVE_RIGHT && (32'(head_r[t]) + 32'd1) < lim)
          head_nxt[t] = head_r[t] + AW'(1);
      end
    end
    if (cmd.begin_init) begin
      mst_nxt = start_r;
      step_cnt_nxt = '0;
    end else if (cmd.apply) begin
      mst_nxt = rule_q.to_st;
      step_cnt_nxt = step_cnt_r + 32'd1;
    end else if (cmd.set_reject) begin
      mst_nxt = rej_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < TAPES; t++) head_r[t] <= '0;
      mst_r <= '0;
      step_cnt_r <= '0;
    end else begin
      for (int t = 0; t < TAPES; t++) head_r[t] <= head_nxt[t];
      mst_r <= mst_nxt;
      step_cnt_r <= step_cnt_nxt;
    end
  end

  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0] run_status;

  always_comb begin
    if (mst_r == acc_r) run_status = STAT_ACCEPT;
    else if (mst_r == rej_r) run_status = STAT_REJECT;
    else run_status = STAT_LIMIT;
    out_data_nxt = '0;
    case (req_r)
      REQ_RUN: begin
        out_data_nxt[1:0] = run_status;
        out_data_nxt[33:2] = step_cnt_r;
        out_data_nxt[37:34] = mst_r;
      end
      REQ_READ: out_data_nxt[45:38] = addr_ok ? sym_q[tape_sel] : SYM_BLANK;
      default: out_data_nxt[1:0] = STAT_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (cmd.load_out) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  assign sts.req = req_r;
  assign sts.clr_last = clr_last;
  assign sts.halt = (step_cnt_r >= step_lim_r) || (mst_r == acc_r) || (mst_r == rej_r);
  assign sts.ridx_end = (32'(ridx_r) >= rule_n);
  assign sts.match = match;
  assign sts.out_free = !out_valid_r || out_tready;

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(head_r[0]) < TAPE_DEPTH) && (32'(head_r[TAPES-1]) < TAPE_DEPTH))
    else $error("head outside tape");

  a_step_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> step_cnt_r == $past(step_cnt_r) + 32'd1)
    else $error("step count not advanced");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwritten");

endmodule

[rtl/multi_tape_turing_step_engine.sv]
// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   in_tuser req_type, in_tdata item fields
// out_     master     out_tvalid/out_tready out_tdata result fields
// cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
// One request at a time.
// Clear-and-begin sweeps the tapes.
// Run: per step, read head cells, then try rules in order (registered rule read).
// After reset a blanking pass runs before in_tready rises.
// A result waits in the output register; the next result waits until it is taken.
module multi_tape_turing_step_engine import mtts_pkg::*; #(
  parameter int TAPE_DEPTH = DEF_TAPE_DEPTH,
  parameter int RULE_DEPTH = DEF_RULE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2:0]            in_tuser,   // req_type
  // rule_index, from_state, read_pattern, to_state, write_pattern,
  // move_pattern, tape_sel, cell_pos, cell_sym, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // run_status, steps_taken, halt_state, cell_value, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mtts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtts_dp #(
    .TAPE_DEPTH(TAPE_DEPTH),
    .RULE_DEPTH(RULE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule
